// ----- sv/its_pkg.sv -----
// Shared types, codes and sizes of the interval timing statistics block.
// Used by its_ctrl, its_datapath and interval_timing_statistics; no dependencies.
`default_nettype none

package its_pkg;

	// Table geometry and field widths.
	localparam int NUM_SLOTS = 16;
	localparam int STAMP_W   = 32;
	localparam int SLOT_W    = 5;
	localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
	localparam int TS_W      = 32;
	localparam int COUNT_W   = 32;
	localparam int TOTAL_W   = 48;
	localparam int TICK_W    = 32;

	// Item operations.
	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_STOP  = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_DISABLED = 2'd1,
		ST_UNKNOWN  = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	// Work the datapath does for one request.
	typedef enum logic [2:0] {
		ACT_REPORT,
		ACT_ALLOC,
		ACT_STOP,
		ACT_CODE,
		ACT_CLEAR
	} act_t;

	// Statistics of one slot.
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [TOTAL_W-1:0] total;
		logic [TICK_W-1:0]  least;
		logic [TICK_W-1:0]  most;
	} stat_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    capture;
		logic    execute;
		act_t    act;
		status_t status;
		logic    stamp_wr;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic known;
		logic full;
	} dp_stat_t;

endpackage

`default_nettype wire

// ----- sv/interval_timing_statistics.sv -----
// Top level of the interval timing statistics block.
// Instantiates its_ctrl and its_datapath; depends on its_pkg.
`default_nettype none

// Interval timing statistics table with NUM_SLOTS slots numbered from 1. Start,
// stop, read and clear requests arrive on a valid/ready channel and each gives
// exactly one result. In the accept cycle of a request the slot entry is read
// from the table memories into registers; in the execute state the statistics
// are updated and written back where the request calls for it, and the result
// is loaded into the output register. The execute state waits while the output
// register still holds a result that has not been taken. Only one request is in
// flight at a time. The enable register is written on the configuration channel,
// which is always ready; write it only while no request is in progress. The table
// needs no clearing pass after reset: a slot is fully written when it is allocated.
module interval_timing_statistics (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic                          enable,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [1:0]                    opcode,
	input  wire logic [its_pkg::SLOT_W-1:0]    slot_id,
	input  wire logic [its_pkg::TS_W-1:0]      timestamp,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [its_pkg::SLOT_W-1:0]         slot_out,
	output logic [1:0]                         status,
	output logic [its_pkg::COUNT_W-1:0]        call_count,
	output logic [its_pkg::TOTAL_W-1:0]        total_ticks,
	output logic [its_pkg::TICK_W-1:0]         min_ticks,
	output logic [its_pkg::TICK_W-1:0]         max_ticks
);
	import its_pkg::*;

	cmd_t     cmd;
	dp_stat_t dp_stat;

	// Sequencer and handshakes.
	its_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.enable    (enable),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dp_stat   (dp_stat),
		.cmd       (cmd)
	);

	// Table, arithmetic and result register.
	its_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.slot_id     (slot_id),
		.timestamp   (timestamp),
		.cmd         (cmd),
		.dp_stat     (dp_stat),
		.slot_out    (slot_out),
		.status      (status),
		.call_count  (call_count),
		.total_ticks (total_ticks),
		.min_ticks   (min_ticks),
		.max_ticks   (max_ticks)
	);

endmodule

`default_nettype wire

// ----- sv/its_ctrl.sv -----
// Controller of the interval timing statistics block: handshakes, enable register
// and the two-state sequencer that commands its_datapath. Depends on its_pkg.
`default_nettype none

module its_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic              enable,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        opcode,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire its_pkg::dp_stat_t dp_stat,
	output its_pkg::cmd_t          cmd
);
	import its_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t  state_q;
	logic    enable_q;
	logic    out_valid_q;
	act_t    act_q;
	status_t status_q;
	logic    stamp_wr_q;
	logic    accept;
	logic    out_free;
	act_t    act_d;
	status_t status_d;
	logic    stamp_wr_d;

	// The enable register takes every write at once.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
		end else if (cfg_valid) begin
			enable_q <= enable;
		end
	end

	// Handshake terms.
	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// Decide what the request will do, from the opcode and the table status.
	always_comb begin
		act_d      = ACT_CODE;
		status_d   = ST_OK;
		stamp_wr_d = 1'b0;
		unique case (op_t'(opcode))
			OP_CLEAR: begin
				act_d = ACT_CLEAR;
			end
			OP_READ: begin
				if (dp_stat.known) begin
					act_d = ACT_REPORT;
				end else begin
					status_d = ST_UNKNOWN;
				end
			end
			OP_START: begin
				if (!enable_q) begin
					status_d = ST_DISABLED;
				end else if (dp_stat.known) begin
					act_d      = ACT_REPORT;
					stamp_wr_d = 1'b1;
				end else if (dp_stat.full) begin
					status_d = ST_FULL;
				end else begin
					act_d = ACT_ALLOC;
				end
			end
			OP_STOP: begin
				if (!enable_q) begin
					status_d = ST_DISABLED;
				end else if (dp_stat.known) begin
					act_d = ACT_STOP;
				end else begin
					status_d = ST_UNKNOWN;
				end
			end
			default: begin
				act_d = ACT_CODE;
			end
		endcase
	end

	// Hold the decision for the execute cycle.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q      <= act_d;
			status_q   <= status_d;
			stamp_wr_q <= stamp_wr_d;
		end
	end

	// Sequencer: accept in idle, execute once the output register is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output valid is set by an execute and cleared when the result is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.execute) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Commands to the datapath.
	always_comb begin
		cmd.capture  = accept;
		cmd.execute  = (state_q == S_EXEC) && out_free;
		cmd.act      = act_q;
		cmd.status   = status_q;
		cmd.stamp_wr = stamp_wr_q;
	end

	a_exec_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.execute |-> (!out_valid_q || out_ready))
		else $error("execute issued while the output register is still full");

	a_accept_starts_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_EXEC) && !out_valid_q || (state_q == S_EXEC))
		else $error("accepted request did not move the sequencer to execute");

	a_exec_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.execute |=> (state_q == S_IDLE) && out_valid_q)
		else $error("execute did not load a result");

	a_no_capture_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |-> !cmd.capture)
		else $error("request captured while another is in execution");

endmodule

`default_nettype wire

// ----- sv/its_datapath.sv -----
// Datapath of the interval timing statistics block: slot table memories, slot
// count, stop arithmetic and the output register. Depends on its_pkg.
`default_nettype none

module its_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [its_pkg::SLOT_W-1:0]    slot_id,
	input  wire logic [its_pkg::TS_W-1:0]      timestamp,
	input  wire its_pkg::cmd_t                 cmd,
	output its_pkg::dp_stat_t                  dp_stat,
	output logic [its_pkg::SLOT_W-1:0]         slot_out,
	output logic [1:0]                         status,
	output logic [its_pkg::COUNT_W-1:0]        call_count,
	output logic [its_pkg::TOTAL_W-1:0]        total_ticks,
	output logic [its_pkg::TICK_W-1:0]         min_ticks,
	output logic [its_pkg::TICK_W-1:0]         max_ticks
);
	import its_pkg::*;

	localparam logic [TOTAL_W:0] TOTAL_SAT = {1'b0, {TOTAL_W{1'b1}}};

	logic [STAMP_W-1:0] stamp_mem [NUM_SLOTS];
	stat_t              stat_mem  [NUM_SLOTS];

	logic [CNT_W-1:0]   count_q;
	logic [SLOT_W-1:0]  id_q;
	logic [STAMP_W-1:0] ts_q;
	logic [STAMP_W-1:0] stamp_rd_q;
	stat_t              stat_rd_q;

	logic [IDX_W-1:0]   rd_idx;
	logic [IDX_W-1:0]   id_idx;
	logic [IDX_W-1:0]   wr_idx;
	logic               stamp_we;
	logic               stat_we;
	stat_t              stat_wd;

	logic [STAMP_W-1:0] elapsed;
	logic [63:0]        elapsed_ext;
	logic [TICK_W-1:0]  elapsed_clip;
	logic [TOTAL_W:0]   sum_wide;
	stat_t              stat_stop;
	stat_t              stat_fresh;

	logic [SLOT_W-1:0]  slot_q;
	status_t            status_q;
	stat_t              stat_out_q;

	// Table status for the request at the input.
	always_comb begin
		dp_stat.known = (slot_id != '0) && (slot_id <= SLOT_W'(count_q));
		dp_stat.full  = (count_q == CNT_W'(NUM_SLOTS));
	end

	assign rd_idx = IDX_W'(slot_id - SLOT_W'(1));
	assign id_idx = IDX_W'(id_q - SLOT_W'(1));

	// Capture the request payload.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			id_q <= slot_id;
			ts_q <= STAMP_W'(timestamp);
		end
	end

	// Stop arithmetic: elapsed ticks, clipped for min and max, saturating total.
	always_comb begin
		elapsed      = ts_q - stamp_rd_q;
		elapsed_ext  = 64'(elapsed);
		elapsed_clip = (elapsed_ext[63:TICK_W] != '0) ? '1 : elapsed_ext[TICK_W-1:0];
		sum_wide     = (TOTAL_W+1)'(stat_rd_q.total) + (TOTAL_W+1)'(elapsed_ext);

		stat_stop.total = (sum_wide >= TOTAL_SAT) ? '1 : sum_wide[TOTAL_W-1:0];
		stat_stop.least = (elapsed_clip < stat_rd_q.least) ? elapsed_clip : stat_rd_q.least;
		stat_stop.most  = (elapsed_clip > stat_rd_q.most) ? elapsed_clip : stat_rd_q.most;
		stat_stop.count = (stat_rd_q.count != '1) ? stat_rd_q.count + COUNT_W'(1)
			: stat_rd_q.count;

		stat_fresh.count = '0;
		stat_fresh.total = '0;
		stat_fresh.least = '1;
		stat_fresh.most  = '0;
	end

	// Table write port control.
	always_comb begin
		stamp_we = 1'b0;
		stat_we  = 1'b0;
		wr_idx   = id_idx;
		stat_wd  = stat_stop;
		if (cmd.execute) begin
			unique case (cmd.act)
				ACT_REPORT: begin
					stamp_we = cmd.stamp_wr;
				end
				ACT_ALLOC: begin
					stamp_we = 1'b1;
					stat_we  = 1'b1;
					wr_idx   = IDX_W'(count_q);
					stat_wd  = stat_fresh;
				end
				ACT_STOP: begin
					stat_we = 1'b1;
				end
				ACT_CODE, ACT_CLEAR: begin
					stamp_we = 1'b0;
				end
				default: begin
					stamp_we = 1'b0;
				end
			endcase
		end
	end

	// Slot table memories, read at capture with registered data.
	always_ff @(posedge clk) begin
		if (stamp_we) begin
			stamp_mem[wr_idx] <= ts_q;
		end
		if (stat_we) begin
			stat_mem[wr_idx] <= stat_wd;
		end
		if (cmd.capture) begin
			stamp_rd_q <= stamp_mem[rd_idx];
			stat_rd_q  <= stat_mem[rd_idx];
		end
	end

	// Allocated slot count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.execute && (cmd.act == ACT_ALLOC)) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.execute && (cmd.act == ACT_CLEAR)) begin
			count_q <= '0;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			status_q <= cmd.status;
			unique case (cmd.act)
				ACT_REPORT: begin
					slot_q     <= id_q;
					stat_out_q <= stat_rd_q;
				end
				ACT_ALLOC: begin
					slot_q     <= SLOT_W'(count_q) + SLOT_W'(1);
					stat_out_q <= stat_fresh;
				end
				ACT_STOP: begin
					slot_q     <= id_q;
					stat_out_q <= stat_stop;
				end
				ACT_CODE, ACT_CLEAR: begin
					slot_q     <= '0;
					stat_out_q <= '0;
				end
				default: begin
					slot_q     <= '0;
					stat_out_q <= '0;
				end
			endcase
		end
	end

	assign slot_out    = slot_q;
	assign status      = status_q;
	assign call_count  = stat_out_q.count;
	assign total_ticks = stat_out_q.total;
	assign min_ticks   = stat_out_q.least;
	assign max_ticks   = stat_out_q.most;

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(NUM_SLOTS))
		else $error("slot count beyond table size");

	a_no_alloc_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.execute && (cmd.act == ACT_ALLOC)) |-> (count_q != CNT_W'(NUM_SLOTS)))
		else $error("allocation on a full table");

	a_stop_result_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.execute && (cmd.act == ACT_STOP)) |=> (slot_out != '0) && (status == ST_OK))
		else $error("stop update produced no slot in its result");

endmodule

`default_nettype wire
